// ----- rtl/core/lssc_pkg.sv -----
// Package for the list smooth-scroll controller: request and result item types,
// command codes, register indexes, controller-to-datapath signal groups.
// No dependencies.
package lssc_pkg;

  localparam int RING_ROWS_DEF = 32;

  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_UP      = 3'd1;
  localparam logic [2:0] CMD_DOWN    = 3'd2;
  localparam logic [2:0] CMD_SET     = 3'd3;
  localparam logic [2:0] CMD_PREPARE = 3'd4;
  localparam logic [2:0] CMD_TICK    = 3'd5;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_BULK  = 2'd1;
  localparam logic [1:0] KIND_STAGE = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  localparam logic [2:0] REG_TRACK_COUNT    = 3'd0;
  localparam logic [2:0] REG_START_TRACK    = 3'd1;
  localparam logic [2:0] REG_VISIBLE_ROWS   = 3'd2;
  localparam logic [2:0] REG_CENTER_ROW     = 3'd3;
  localparam logic [2:0] REG_SCROLL_STEP    = 3'd4;
  localparam logic [2:0] REG_BOTTOM_PADDING = 3'd5;

  localparam logic [7:0] ROW_NONE  = 8'hFF;
  localparam logic [7:0] MARK_BASE = 8'd16;
  localparam logic [7:0] MARK_MAX  = 8'd120;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] set_index;
    logic [7:0] playing_track;
  } req_item_t;

  typedef struct packed {
    logic [7:0] cursor_index;
    logic [7:0] view_top;
    logic [7:0] scroll_offset;
    logic       cursor_mark_shown;
    logic [7:0] cursor_mark_y;
    logic       playing_mark_shown;
    logic [7:0] playing_mark_y;
    logic [1:0] render_kind;
    logic [7:0] render_first;
    logic [7:0] render_last;
    logic       name_redraw;
  } res_item_t;

  typedef struct packed {
    logic [7:0] track_count;
    logic [7:0] start_track;
    logic [4:0] visible_rows;
    logic [4:0] center_row;
    logic [3:0] scroll_step;
    logic [2:0] bottom_padding;
  } cfg_t;

  typedef struct packed {
    logic ld_req;
    logic exec;
    logic mod_step;
    logic fill_start;
    logic fill_step;
    logic fill_fin;
    logic prep_chk;
    logic flush_wr;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0] req_cmd;
    logic       exec_to_mod;
    logic       mod_done;
    logic       fill_done;
  } dp_sts_t;

endpackage

// ----- rtl/core/list_smooth_scroll_controller_unit.sv -----
// Top level of the list smooth-scroll controller: APB register file, result register,
// sequencer and datapath. Depends on lssc_pkg, lssc_ctrl and lssc_dpath.
//
// Each request is taken only when the previous one has finished its work; a finished
// result waits in the output register while the next request is taken. Cursor up, down,
// unknown codes and a frame tick with nothing staged go from execute straight to the result
// hand-off. Init, set, prepare and a tick that flushes a staged row first reduce the row to a
// ring index (one subtraction of RING_ROWS per cycle). Init and set then walk the ring one
// entry per cycle through the ring memory, which reads one entry and writes another at once.
// Reset empties the ring at once; no clearing pass is needed.
module list_smooth_scroll_controller_unit #(
  parameter int RING_ROWS = lssc_pkg::RING_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  lssc_pkg::req_item_t cmd_data,
  output logic                res_valid,
  input  logic                res_ready,
  output lssc_pkg::res_item_t res_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lssc_pkg::*;

  cfg_t      cfg;
  dp_ctl_t   ctl;
  dp_sts_t   sts;
  res_item_t res_comb;
  logic      load_res;
  logic      res_busy;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_count    <= 8'd1;
      cfg.start_track    <= 8'd1;
      cfg.visible_rows   <= 5'd18;
      cfg.center_row     <= 5'd7;
      cfg.scroll_step    <= 4'd2;
      cfg.bottom_padding <= 3'd4;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_TRACK_COUNT:    cfg.track_count    <= pwdata[7:0];
        REG_START_TRACK:    cfg.start_track    <= pwdata[7:0];
        REG_VISIBLE_ROWS:   cfg.visible_rows   <= pwdata[4:0];
        REG_CENTER_ROW:     cfg.center_row     <= pwdata[4:0];
        REG_SCROLL_STEP:    cfg.scroll_step    <= pwdata[3:0];
        REG_BOTTOM_PADDING: cfg.bottom_padding <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRACK_COUNT:    prdata = {24'd0, cfg.track_count};
      REG_START_TRACK:    prdata = {24'd0, cfg.start_track};
      REG_VISIBLE_ROWS:   prdata = {27'd0, cfg.visible_rows};
      REG_CENTER_ROW:     prdata = {27'd0, cfg.center_row};
      REG_SCROLL_STEP:    prdata = {28'd0, cfg.scroll_step};
      REG_BOTTOM_PADDING: prdata = {29'd0, cfg.bottom_padding};
      default:            prdata = 32'd0;
    endcase
  end

  assign res_busy = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_data <= res_comb;
    end
  end

  lssc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (cmd_valid),
    .req_ready (cmd_ready),
    .res_busy  (res_busy),
    .sts       (sts),
    .ctl       (ctl),
    .load_res  (load_res)
  );

  lssc_dpath #(
    .RING_ROWS (RING_ROWS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .req_in (cmd_data),
    .ctl    (ctl),
    .sts    (sts),
    .res    (res_comb)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("request taken while another is in progress");

endmodule

// ----- rtl/core/lssc_ctrl.sv -----
// Sequencer for the list smooth-scroll controller.
// Steps the datapath through execute, ring index reduction, ring walk, prepare check and result hand-off.
// Depends on lssc_pkg.
module lssc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              res_busy,
  input  lssc_pkg::dp_sts_t sts,
  output lssc_pkg::dp_ctl_t ctl,
  output logic              load_res
);
  import lssc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MOD  = 6'b000100,
    S_FILL = 6'b001000,
    S_PREP = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    load_res   = 1'b0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.ld_req = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = sts.exec_to_mod ? S_MOD : S_DONE;
      end
      S_MOD: begin
        ctl.mod_step = 1'b1;
        if (sts.mod_done) begin
          unique case (sts.req_cmd)
            CMD_INIT, CMD_SET: begin
              ctl.fill_start = 1'b1;
              state_next     = S_FILL;
            end
            CMD_PREPARE: begin
              state_next = S_PREP;
            end
            CMD_TICK: begin
              ctl.flush_wr = 1'b1;
              state_next   = S_DONE;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_FILL: begin
        ctl.fill_step = 1'b1;
        if (sts.fill_done) begin
          ctl.fill_fin = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_PREP: begin
        ctl.prep_chk = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!res_busy) begin
          load_res   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/lssc_dpath.sv -----
// Datapath for the list smooth-scroll controller: cursor and scroll state, ring cache
// memory with valid bits, index reduction, ring walk and marker arithmetic.
// Depends on lssc_pkg.
module lssc_dpath #(
  parameter int RING_ROWS = lssc_pkg::RING_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lssc_pkg::cfg_t      cfg,
  input  lssc_pkg::req_item_t req_in,
  input  lssc_pkg::dp_ctl_t   ctl,
  output lssc_pkg::dp_sts_t   sts,
  output lssc_pkg::res_item_t res
);
  import lssc_pkg::*;

  localparam int RW = $clog2(RING_ROWS);

  req_item_t   req;
  logic [7:0]  cursor_pos;
  logic [7:0]  top_row;
  logic [7:0]  target_offset;
  logic [7:0]  current_offset;
  logic [7:0]  previous_top;
  logic [7:0]  staged_row;
  logic [7:0]  drawn_name_track;
  logic [7:0]  work_row;
  logic [7:0]  mod_rem;
  logic [7:0]  fill_row;
  logic [7:0]  fill_hi;
  logic [RW-1:0] fill_idx;
  logic        fill_issue;
  logic        fill_pend;
  logic [7:0]  pend_row;
  logic [RW-1:0] pend_idx;
  logic        dirty;
  logic [1:0]  kind;
  logic [7:0]  first_row;
  logic [7:0]  last_row;
  logic        redraw;

  logic [7:0]  ring [RING_ROWS];
  logic        ring_valid [RING_ROWS];
  logic [7:0]  rd_data;

  logic [7:0]  eff_count;
  logic [8:0]  len_sum;
  logic [7:0]  list_len;
  logic [7:0]  last_track;
  logic [7:0]  start_pos;
  logic [7:0]  new_cursor;
  logic [7:0]  new_top;
  logic [7:0]  new_target;
  logic [7:0]  max_top;
  logic [7:0]  cur_less;
  logic [8:0]  prep_row;
  logic        exec_to_mod;
  logic [7:0]  anim_diff;
  logic [8:0]  anim_delta;
  logic [8:0]  anim_step;
  logic [7:0]  anim_next;
  logic [8:0]  hi_span;
  logic [8:0]  hi_list;
  logic [RW-1:0] mod_idx;
  logic [RW-1:0] rd_idx;
  logic        wr_en;
  logic [RW-1:0] wr_idx;
  logic [7:0]  wr_data;
  logic [7:0]  pv;
  logic [7:0]  cy;
  logic [7:0]  py;
  logic [8:0]  view_end;
  logic        in_view;

  always_comb begin
    eff_count  = (cfg.track_count == 8'd0) ? 8'd1 : cfg.track_count;
    len_sum    = {1'b0, eff_count} + {6'd0, cfg.bottom_padding};
    list_len   = len_sum[8] ? 8'hFF : len_sum[7:0];
    last_track = eff_count - 8'd1;
    start_pos  = (cfg.start_track == 8'd0) ? 8'd0 : cfg.start_track - 8'd1;
    if (start_pos > last_track) begin
      start_pos = last_track;
    end
  end

  always_comb begin
    new_cursor = cursor_pos;
    unique case (req.cmd)
      CMD_INIT: begin
        new_cursor = start_pos;
      end
      CMD_UP: begin
        new_cursor = cursor_pos - 8'd1;
      end
      CMD_DOWN: begin
        new_cursor = cursor_pos + 8'd1;
      end
      CMD_SET: begin
        new_cursor = (req.set_index > last_track) ? last_track : req.set_index;
      end
      default: begin
        new_cursor = cursor_pos;
      end
    endcase
  end

  always_comb begin
    max_top  = list_len - {3'd0, cfg.visible_rows};
    cur_less = new_cursor - {3'd0, cfg.center_row};
    if (list_len <= {3'd0, cfg.visible_rows}) begin
      new_top = 8'd0;
    end else if (new_cursor <= {3'd0, cfg.center_row}) begin
      new_top = 8'd0;
    end else begin
      new_top = (cur_less > max_top) ? max_top : cur_less;
    end
    new_target = {new_top[4:0], 3'b000};
  end

  always_comb begin
    if (top_row > previous_top) begin
      if (cfg.visible_rows == 5'd0) begin
        prep_row = {1'b0, top_row - 8'd1};
      end else begin
        prep_row = {1'b0, top_row} + {4'd0, cfg.visible_rows} - 9'd1;
      end
    end else begin
      prep_row = {1'b0, top_row};
    end
  end

  always_comb begin
    unique case (req.cmd)
      CMD_INIT, CMD_SET: exec_to_mod = 1'b1;
      CMD_PREPARE: exec_to_mod = (top_row != previous_top) && (prep_row < {1'b0, list_len});
      CMD_TICK: exec_to_mod = (staged_row != ROW_NONE);
      default: exec_to_mod = 1'b0;
    endcase
  end

  always_comb begin
    anim_diff  = target_offset - current_offset;
    anim_delta = {anim_diff[7], anim_diff};
    anim_step  = {5'd0, cfg.scroll_step};
    if (anim_diff == 8'd0) begin
      anim_next = current_offset;
    end else if ($signed(anim_delta) >= $signed(anim_step)) begin
      anim_next = current_offset + {4'd0, cfg.scroll_step};
    end else if ($signed(anim_delta) <= -$signed(anim_step)) begin
      anim_next = current_offset - {4'd0, cfg.scroll_step};
    end else begin
      anim_next = target_offset;
    end
  end

  assign hi_span = {1'b0, top_row} + 9'(RING_ROWS - 1);
  assign hi_list = {1'b0, list_len} - 9'd1;
  assign mod_idx = mod_rem[RW-1:0];
  assign rd_idx  = fill_issue ? fill_idx : mod_idx;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = pend_idx;
    wr_data = pend_row;
    if (ctl.fill_step && fill_pend) begin
      wr_en = 1'b1;
    end else if (ctl.flush_wr) begin
      wr_en   = 1'b1;
      wr_idx  = mod_idx;
      wr_data = work_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_idx] <= wr_data;
    end
    rd_data <= ring[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.exec && req.cmd == CMD_INIT)) begin
      for (int i = 0; i < RING_ROWS; i++) begin
        ring_valid[i] <= 1'b0;
      end
    end else if (wr_en) begin
      ring_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_pos       <= 8'd0;
      top_row          <= 8'd0;
      target_offset    <= 8'd0;
      current_offset   <= 8'd0;
      previous_top     <= 8'd0;
      staged_row       <= ROW_NONE;
      drawn_name_track <= 8'd0;
      fill_issue       <= 1'b0;
      fill_pend        <= 1'b0;
      kind             <= KIND_NONE;
      first_row        <= 8'd0;
      last_row         <= 8'd0;
      redraw           <= 1'b0;
    end else begin
      if (ctl.ld_req) begin
        req       <= req_in;
        kind      <= KIND_NONE;
        first_row <= 8'd0;
        last_row  <= 8'd0;
        redraw    <= 1'b0;
      end
      if (ctl.exec) begin
        unique case (req.cmd)
          CMD_INIT: begin
            cursor_pos       <= new_cursor;
            top_row          <= new_top;
            target_offset    <= new_target;
            current_offset   <= new_target;
            previous_top     <= new_top;
            staged_row       <= ROW_NONE;
            drawn_name_track <= req.playing_track;
            redraw           <= 1'b1;
            mod_rem          <= new_top;
          end
          CMD_UP: begin
            if (cursor_pos != 8'd0) begin
              cursor_pos    <= new_cursor;
              top_row       <= new_top;
              target_offset <= new_target;
            end
          end
          CMD_DOWN: begin
            if (cursor_pos < last_track) begin
              cursor_pos    <= new_cursor;
              top_row       <= new_top;
              target_offset <= new_target;
            end
          end
          CMD_SET: begin
            cursor_pos     <= new_cursor;
            top_row        <= new_top;
            target_offset  <= new_target;
            current_offset <= new_target;
            previous_top   <= new_top;
            mod_rem        <= new_top;
          end
          CMD_PREPARE: begin
            if (top_row != previous_top) begin
              previous_top <= top_row;
              work_row     <= prep_row[7:0];
              mod_rem      <= prep_row[7:0];
            end
          end
          CMD_TICK: begin
            if (staged_row != ROW_NONE) begin
              kind       <= KIND_FLUSH;
              first_row  <= staged_row;
              last_row   <= staged_row;
              work_row   <= staged_row;
              mod_rem    <= staged_row;
              staged_row <= ROW_NONE;
            end
            current_offset <= anim_next;
            if (req.playing_track != drawn_name_track) begin
              drawn_name_track <= req.playing_track;
              redraw           <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl.mod_step && !sts.mod_done) begin
        mod_rem <= mod_rem - 8'(RING_ROWS);
      end
      if (ctl.fill_start) begin
        fill_row   <= top_row;
        fill_idx   <= mod_idx;
        fill_hi    <= (hi_span > hi_list) ? hi_list[7:0] : hi_span[7:0];
        fill_issue <= 1'b1;
        fill_pend  <= 1'b0;
        dirty      <= 1'b0;
      end
      if (ctl.fill_step) begin
        if (fill_pend && (!ring_valid[pend_idx] || rd_data != pend_row)) begin
          dirty <= 1'b1;
        end
        fill_pend <= fill_issue;
        pend_row  <= fill_row;
        pend_idx  <= fill_idx;
        if (fill_issue) begin
          fill_row <= fill_row + 8'd1;
          fill_idx <= (fill_idx == RW'(RING_ROWS - 1)) ? '0 : fill_idx + 1'b1;
          if (fill_row == fill_hi) begin
            fill_issue <= 1'b0;
          end
        end
      end
      if (ctl.fill_fin && dirty) begin
        kind      <= KIND_BULK;
        first_row <= top_row;
        last_row  <= fill_hi;
      end
      if (ctl.prep_chk && (!ring_valid[mod_idx] || rd_data != work_row)) begin
        staged_row <= work_row;
        kind       <= KIND_STAGE;
        first_row  <= work_row;
        last_row   <= work_row;
      end
    end
  end

  assign sts.req_cmd     = req.cmd;
  assign sts.exec_to_mod = exec_to_mod;
  assign sts.mod_done    = (mod_rem < 8'(RING_ROWS));
  assign sts.fill_done   = !fill_issue && !fill_pend;

  always_comb begin
    pv       = req.playing_track - 8'd1;
    cy       = {cursor_pos[4:0], 3'b000} - current_offset + MARK_BASE;
    view_end = {1'b0, top_row} + {4'd0, cfg.visible_rows};
    in_view  = (pv >= top_row) && ({1'b0, pv} < view_end);
    py       = 8'd0;
    if (req.playing_track != 8'd0) begin
      py = {pv[4:0], 3'b000} - current_offset + MARK_BASE;
    end
    res.cursor_index       = cursor_pos;
    res.view_top           = top_row;
    res.scroll_offset      = current_offset;
    res.cursor_mark_shown  = (cy >= 8'd1) && (cy <= MARK_MAX);
    res.cursor_mark_y      = cy;
    res.playing_mark_shown = (req.playing_track != 8'd0) && in_view && (pv != cursor_pos)
                             && (py >= 8'd1) && (py <= MARK_MAX);
    res.playing_mark_y     = py;
    res.render_kind        = kind;
    res.render_first       = first_row;
    res.render_last        = last_row;
    res.name_redraw        = redraw;
  end

  a_fill_no_collide: assert property (@(posedge clk) disable iff (rst)
    (fill_pend && fill_issue) |-> (pend_idx != fill_idx))
    else $error("ring walk writes the entry it reads");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_issue |-> (fill_row <= fill_hi))
    else $error("ring walk passed its last row");

  a_prep_reduced: assert property (@(posedge clk) disable iff (rst)
    (ctl.prep_chk || ctl.flush_wr || ctl.fill_start) |-> (mod_rem < 8'(RING_ROWS)))
    else $error("ring index not reduced");

endmodule
